/* hdl/spq_pkg.sv */
// Shared types and constants for the stable priority queue.
`default_nettype none

package spq_pkg;

  // Fixed widths of the stream fields
  localparam int unsigned ItemDataW = 32;
  localparam int unsigned ItemPrioW = 8;
  localparam int unsigned OccW      = 5;
  localparam int unsigned StatusW   = 2;

  // Packed stream words, zero padded to whole bytes
  localparam int unsigned InTdataW  = 40;
  localparam int unsigned OutTdataW = 48;

  // Operation codes carried in tuser of the input stream
  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  // Result codes carried in tuser of the output stream
  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic ins_en;  // insert the new entry into the sorted chain
    logic pop_en;  // shift the chain toward the front
  } cell_cmd_t;

endpackage : spq_pkg

`default_nettype wire

/* hdl/spq_cell.sv */
// One slot of the sorted shift chain: holds an entry, keeps, shifts or takes the new one.
`default_nettype none

module spq_cell
  import spq_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned PRIO_WIDTH = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cell_cmd_t             cmd_i,
  input  wire logic [DATA_WIDTH-1:0] new_data_i,
  input  wire logic [PRIO_WIDTH-1:0] new_prio_i,
  // neighbor toward the front
  input  wire logic                  left_behind_i,
  input  wire logic                  left_valid_i,
  input  wire logic [DATA_WIDTH-1:0] left_data_i,
  input  wire logic [PRIO_WIDTH-1:0] left_prio_i,
  // neighbor toward the back
  input  wire logic                  right_valid_i,
  input  wire logic [DATA_WIDTH-1:0] right_data_i,
  input  wire logic [PRIO_WIDTH-1:0] right_prio_i,
  // own contents
  output logic                       behind_o,
  output logic                       valid_o,
  output logic [DATA_WIDTH-1:0]      data_o,
  output logic [PRIO_WIDTH-1:0]      prio_o
);

  logic                  valid_q, valid_d;
  logic [DATA_WIDTH-1:0] data_q, data_d;
  logic [PRIO_WIDTH-1:0] prio_q, prio_d;

  // New entry belongs behind this one (ties keep arrival order)
  assign behind_o = valid_q && (prio_q <= new_prio_i);

  // Next contents
  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    prio_d  = prio_q;
    if (cmd_i.ins_en) begin
      if (!behind_o) begin
        if (left_behind_i) begin
          // insertion point
          valid_d = 1'b1;
          data_d  = new_data_i;
          prio_d  = new_prio_i;
        end else begin
          // make room: take the neighbor's entry
          valid_d = left_valid_i;
          data_d  = left_data_i;
          prio_d  = left_prio_i;
        end
      end
    end else if (cmd_i.pop_en) begin
      valid_d = right_valid_i;
      data_d  = right_data_i;
      prio_d  = right_prio_i;
    end
  end

  // Valid bit is control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    prio_q <= prio_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign prio_o  = prio_q;

endmodule : spq_cell

`default_nettype wire

/* hdl/stable_priority_queue.sv */
// Top level of the stable priority queue: stream ports, cell chain, result register.
//
// Usage:
//   Input stream (s_axis_*): tuser is the opcode (0 insert, 1 pop), tdata
//   carries the data word and the priority of an insert. Output stream
//   (m_axis_*): one result transaction per input transaction; tuser is the
//   status (0 ok, 1 insert dropped because full, 2 pop on empty queue), tdata
//   holds the popped data and priority (zero when nothing was popped) and the
//   occupancy after the operation.
//   Entries leave lowest priority value first; equal values leave in arrival
//   order. The store is a chain of DEPTH cells that all compare against the
//   new priority in the same cycle, so an insert or pop updates the whole chain at once.
//   Result: registered, on m_axis in the cycle after the input transaction.
//   Throughput: one transaction per cycle while the output is taken; the
//   output register lets a new input in during the cycle its result leaves.
//   Receiver stall: the result register holds and s_axis_tready drops until
//   the pending result is taken; queue contents are untouched.
//   Reset: the queue is empty and no result is pending; no clearing pass.
`default_nettype none

module stable_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned PRIO_WIDTH = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input stream
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  input  wire logic [InTdataW-1:0]  s_axis_tdata,  // [31:0] item_data, [39:32] item_priority
  input  wire logic                 s_axis_tuser,  // [0] opcode
  // output stream
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output logic [OutTdataW-1:0]      m_axis_tdata,  // [31:0] front_data, [39:32] front_priority,
                                                   // [44:40] occupancy, [47:45] zero
  output logic [StatusW-1:0]        m_axis_tuser   // [1:0] status
);

  localparam int unsigned CntW  = $clog2(DEPTH + 1);
  localparam int unsigned DataX = (DATA_WIDTH > ItemDataW) ? DATA_WIDTH : ItemDataW;
  localparam int unsigned PrioX = (PRIO_WIDTH > ItemPrioW) ? PRIO_WIDTH : ItemPrioW;
  localparam int unsigned OccX  = (CntW > OccW) ? CntW : OccW;

  // Input decode
  logic                  in_acc;
  op_e                   in_op;
  logic [ItemDataW-1:0]  in_data_raw;
  logic [ItemPrioW-1:0]  in_prio_raw;
  logic [DataX-1:0]      in_data_x;
  logic [PrioX-1:0]      in_prio_x;
  logic [DATA_WIDTH-1:0] new_data;
  logic [PRIO_WIDTH-1:0] new_prio;

  assign in_op       = op_e'(s_axis_tuser);
  assign in_data_raw = s_axis_tdata[ItemDataW-1:0];
  assign in_prio_raw = s_axis_tdata[ItemDataW+ItemPrioW-1:ItemDataW];
  assign in_data_x   = DataX'(in_data_raw);
  assign in_prio_x   = PrioX'(in_prio_raw);
  assign new_data    = in_data_x[DATA_WIDTH-1:0];
  assign new_prio    = in_prio_x[PRIO_WIDTH-1:0];

  // Result register and occupancy
  logic                 out_valid_q;
  status_e              out_status_q, out_status_d;
  logic [ItemDataW-1:0] out_data_q, out_data_d;
  logic [ItemPrioW-1:0] out_prio_q, out_prio_d;
  logic [OccW-1:0]      out_occ_q, out_occ_d;
  logic [CntW-1:0]      count_q, count_d;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Cell chain wiring
  logic [DEPTH-1:0]      cell_valid;
  logic [DEPTH-1:0]      cell_behind;
  logic [DATA_WIDTH-1:0] cell_data [DEPTH];
  logic [PRIO_WIDTH-1:0] cell_prio [DEPTH];
  cell_cmd_t             cmd;

  logic is_full, is_empty;
  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  always_comb begin
    cmd.ins_en = in_acc && (in_op == OP_INSERT) && !is_full;
    cmd.pop_en = in_acc && (in_op == OP_POP) && !is_empty;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                  l_behind, l_valid, r_valid;
    logic [DATA_WIDTH-1:0] l_data, r_data;
    logic [PRIO_WIDTH-1:0] l_prio, r_prio;

    // Front cell: the new entry lands here unless it goes behind it
    if (i == 0) begin : g_front
      assign l_behind = 1'b1;
      assign l_valid  = 1'b0;
      assign l_data   = new_data;
      assign l_prio   = new_prio;
    end else begin : g_mid
      assign l_behind = cell_behind[i-1];
      assign l_valid  = cell_valid[i-1];
      assign l_data   = cell_data[i-1];
      assign l_prio   = cell_prio[i-1];
    end

    // Back cell empties on a pop
    if (i == DEPTH - 1) begin : g_back
      assign r_valid = 1'b0;
      assign r_data  = cell_data[i];
      assign r_prio  = cell_prio[i];
    end else begin : g_next
      assign r_valid = cell_valid[i+1];
      assign r_data  = cell_data[i+1];
      assign r_prio  = cell_prio[i+1];
    end

    spq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .PRIO_WIDTH (PRIO_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .new_data_i    (new_data),
      .new_prio_i    (new_prio),
      .left_behind_i (l_behind),
      .left_valid_i  (l_valid),
      .left_data_i   (l_data),
      .left_prio_i   (l_prio),
      .right_valid_i (r_valid),
      .right_data_i  (r_data),
      .right_prio_i  (r_prio),
      .behind_o      (cell_behind[i]),
      .valid_o       (cell_valid[i]),
      .data_o        (cell_data[i]),
      .prio_o        (cell_prio[i])
    );
  end

  // Result of the current transaction
  logic [DataX-1:0] front_data_x;
  logic [PrioX-1:0] front_prio_x;
  logic [OccX-1:0]  occ_x;

  assign front_data_x = DataX'(cell_data[0]);
  assign front_prio_x = PrioX'(cell_prio[0]);
  assign occ_x        = OccX'(count_d);

  always_comb begin
    count_d      = count_q;
    out_status_d = ST_OK;
    out_data_d   = '0;
    out_prio_d   = '0;
    if (cmd.ins_en) begin
      count_d = count_q + CntW'(1);
    end else if (cmd.pop_en) begin
      count_d    = count_q - CntW'(1);
      out_data_d = front_data_x[ItemDataW-1:0];
      out_prio_d = front_prio_x[ItemPrioW-1:0];
    end else if (in_op == OP_INSERT) begin
      out_status_d = ST_FULL;
    end else begin
      out_status_d = ST_EMPTY;
    end
    out_occ_d = occ_x[OccW-1:0];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (in_acc) begin
        out_valid_q <= 1'b1;
        count_q     <= count_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
      out_prio_q   <= out_prio_d;
      out_occ_q    <= out_occ_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {3'b000, out_occ_q, out_prio_q, out_data_q};

  // Occupied cells always match the entry count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("cell valid bits disagree with entry count");

  // Occupied cells form a solid run from the front
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + DEPTH'(1)) & cell_valid) == '0)
    else $error("gap in the occupied cells");

  // A pop on an empty queue reports empty with no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_op == OP_POP && is_empty) |=>
      (m_axis_tuser == ST_EMPTY && m_axis_tdata[ItemDataW-1:0] == '0))
    else $error("empty pop not reported");

  // A successful insert grows the queue by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_en |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("insert did not grow the queue");

endmodule : stable_priority_queue

`default_nettype wire
